// ----- src/assert_macros.svh -----
// Assertion macros for the checker file of the token classifier
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset
`define NTC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
   else $error("token classifier check failed");

// Property checked at every rising clock edge, reset included
`define NTC_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
   else $error("token classifier check failed");

`endif

// ----- src/ntc_pkg.sv -----
// Types and constants of the numeric token classifier
package ntc_pkg;

   // Token classes as carried on the result channel
   typedef enum logic [2:0] {
      CLASS_INT     = 3'd0,
      CLASS_HEX     = 3'd1,
      CLASS_FLOAT   = 3'd2,
      CLASS_STRING  = 3'd3,
      CLASS_COMMAND = 3'd4
   } class_type;

   // Kind of the last accepted character
   typedef enum logic [2:0] {
      KIND_START = 3'd0,
      KIND_DIGIT = 3'd1,
      KIND_SIGN  = 3'd2,
      KIND_EXPO  = 3'd3,
      KIND_DOT   = 3'd4
   } kind_type;

   // Characters the decoder looks for
   localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'
   localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'
   localparam logic [7:0] CHAR_X     = 8'h78;  // 'x'
   localparam logic [7:0] CHAR_DOT   = 8'h2E;  // '.'
   localparam logic [7:0] CHAR_E     = 8'h65;  // 'e'
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
   localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
   localparam logic [7:0] CHAR_QUOTE = 8'h22;  // '"'
   localparam logic [7:0] CHAR_A     = 8'h61;  // 'a'
   localparam logic [7:0] CHAR_D     = 8'h64;  // 'd'
   localparam logic [7:0] CHAR_F     = 8'h66;  // 'f'
   localparam logic [7:0] CHAR_UP_A  = 8'h41;  // 'A'
   localparam logic [7:0] CHAR_UP_Z  = 8'h5A;  // 'Z'
   localparam logic [7:0] CASE_BIT   = 8'h20;

   localparam int unsigned RSP_DATA_WIDTH = 8;

   // One input word handed from the input register to the scanner
   typedef struct packed {
      logic [7:0] character;
      logic       is_last;
      logic       is_empty;
   } req_word_type;

endpackage

// ----- src/ntc_scan.sv -----
// Per-token scan state and combinational character decode
module ntc_scan
   import ntc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         step_en,     // word is consumed this cycle
   input  req_word_type word,
   output logic         has_result,  // word ends a token
   output class_type    token_class
);

   typedef struct packed {
      logic [1:0] char_position;
      logic       first_was_zero;
      logic       first_not_digit;
      logic       quoted_string;
      logic       hex_mode;
      kind_type   previous_kind;
      logic       dot_seen;
      logic       exponent_seen;
      logic       rejected;
   } scan_state_type;

   localparam scan_state_type CLEAR_STATE = '{
      char_position:   2'd0,
      first_was_zero:  1'b0,
      first_not_digit: 1'b0,
      quoted_string:   1'b0,
      hex_mode:        1'b0,
      previous_kind:   KIND_START,
      dot_seen:        1'b0,
      exponent_seen:   1'b0,
      rejected:        1'b0
   };

   // Decode one folded character against the decimal/hex rules
   function automatic scan_state_type classify_char(scan_state_type s, logic [7:0] c);
      scan_state_type r;
      r = s;
      case (c) inside
         [CHAR_ZERO:CHAR_NINE]: begin
            r.previous_kind = KIND_DIGIT;
         end
         [CHAR_A:CHAR_D], CHAR_F: begin
            if (!s.hex_mode) r.rejected = 1'b1;
            else r.previous_kind = KIND_DIGIT;
         end
         CHAR_PLUS, CHAR_MINUS: begin
            if (s.hex_mode || (s.previous_kind != KIND_START &&
                               s.previous_kind != KIND_EXPO)) r.rejected = 1'b1;
            else r.previous_kind = KIND_SIGN;
         end
         CHAR_DOT: begin
            if (s.hex_mode || s.dot_seen || s.exponent_seen) begin
               r.rejected = 1'b1;
            end else begin
               r.dot_seen      = 1'b1;
               r.previous_kind = KIND_DOT;
            end
         end
         CHAR_E: begin
            // in hex mode 'e' is just a digit
            if (!s.hex_mode && s.exponent_seen) begin
               r.rejected = 1'b1;
            end else begin
               if (!s.hex_mode) r.exponent_seen = 1'b1;
               r.previous_kind = KIND_EXPO;
            end
         end
         default: begin
            r.rejected = 1'b1;
         end
      endcase
      return r;
   endfunction

   scan_state_type state_ff;
   scan_state_type state_in;
   scan_state_type upd;
   logic [7:0]     folded;
   logic           is_digit;

   // Fold case, update flags, pick the class
   always_comb begin
      folded = word.character;
      if (word.character inside {[CHAR_UP_A:CHAR_UP_Z]}) begin
         folded = word.character | CASE_BIT;
      end
      is_digit = (folded inside {[CHAR_ZERO:CHAR_NINE]});

      upd = state_ff;
      if (state_ff.char_position == 2'd0) begin
         upd.quoted_string   = (folded == CHAR_QUOTE);
         upd.first_not_digit = !is_digit;
         upd.first_was_zero  = (folded == CHAR_ZERO);
         if (folded != CHAR_QUOTE) upd = classify_char(upd, folded);
      end else if (!state_ff.quoted_string && !state_ff.rejected) begin
         // the 'x' of a 0x prefix only switches mode
         if (state_ff.char_position == 2'd1 && state_ff.first_was_zero &&
             folded == CHAR_X) begin
            upd.hex_mode      = 1'b1;
            upd.previous_kind = KIND_START;
         end else begin
            upd = classify_char(upd, folded);
         end
      end
      if (state_ff.char_position != 2'd2) begin
         upd.char_position = state_ff.char_position + 2'd1;
      end

      if (word.is_empty) token_class = CLASS_COMMAND;
      else if (upd.quoted_string) token_class = CLASS_STRING;
      else if (state_ff.char_position == 2'd0 && upd.first_not_digit)
         token_class = CLASS_COMMAND;
      else if (upd.rejected) token_class = CLASS_COMMAND;
      else if (upd.dot_seen || upd.exponent_seen) token_class = CLASS_FLOAT;
      else if (upd.hex_mode) token_class = CLASS_HEX;
      else token_class = CLASS_INT;

      has_result = word.is_last | word.is_empty;
      state_in   = has_result ? CLEAR_STATE : upd;
   end

   // State register, cleared at every token end
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR_STATE;
      end else if (step_en) begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- src/numeric_token_classifier.sv -----
// Top level of the numeric token classifier: input register, scanner, result register
//
// Usage:
//   The token arrives one character per word on the req_ channel: the byte
//   in req_tdata, req_tlast on the final character, req_tuser for an empty
//   token (the byte is then ignored). Letters are matched in either case.
//   One word comes out on the rsp_ channel per token, carrying its class:
//   0 integer, 1 hex integer, 2 float, 3 quoted string, 4 command.
//   rsp_tvalid rises when the last word of the token moves on from the
//   input register into the result register.
//   Throughput: one word per cycle while the result register can take a
//   token end, set by the single decode between the input register and the
//   result register; words that end no token never wait on the result channel.
//   When the receiver stalls, the class waits in the result register and
//   words that end no token keep flowing; the next token end waits in the
//   input register and holds req_tready low until the result register frees.
//   Reset clears the valid bits of both registers and the scan state; the first word after
//   reset starts a new token.
module numeric_token_classifier
   import ntc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] character
   input  logic                      req_tlast,   // is_last
   input  logic                      req_tuser,   // is_empty
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata    // [2:0] token_class, [7:3] zero
);

   logic         in_valid_ff;
   req_word_type in_word_ff;
   logic         rsp_valid_ff;
   class_type    rsp_class_ff;
   logic         has_result;
   class_type    token_class;
   logic         advance;

   ntc_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .word        (in_word_ff),
      .has_result  (has_result),
      .token_class (token_class)
   );

   // Word leaves the input register unless it needs a busy result slot
   assign advance    = in_valid_ff &&
                       (!has_result || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_word_ff <= '{character: req_tdata, is_last: req_tlast, is_empty: req_tuser};
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && has_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && has_result) begin
         rsp_class_ff <= token_class;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH - 3){1'b0}}, rsp_class_ff};

endmodule

// ----- src/ntc_checker.sv -----
// Port-level checks of the numeric token classifier, bound to the top level
`include "assert_macros.svh"

module ntc_checker
   import ntc_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata
);

   logic class_ok;

   // defined class with zero padding
   assign class_ok = (rsp_tdata[2:0] <= CLASS_COMMAND) &&
                     (rsp_tdata[RSP_DATA_WIDTH-1:3] == '0);

   // a stalled result stays offered
   `NTC_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)

   // and its word does not change
   `NTC_ASSERT(a_rsp_stable, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))

   // only defined classes, padding bits zero
   `NTC_ASSERT(a_rsp_class, clock, reset, rsp_tvalid |-> class_ok)

   // reset drops any pending result
   `NTC_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)

endmodule

bind numeric_token_classifier ntc_checker u_ntc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- tb/numeric_token_checker.sv -----
// Scoreboard for the numeric token classifier: predicts each token class and checks the results
module numeric_token_checker
   import ntc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [7:0] character
   input  logic                      req_tlast,   // is_last
   input  logic                      req_tuser,   // is_empty
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [RSP_DATA_WIDTH-1:0] rsp_tdata,   // [2:0] token_class, [7:3] zero
   output int                        error_count,
   output int                        outstanding
);

   // Scan state of the token under way
   logic [1:0] seen_count;
   logic       lead_zero;
   logic       lead_not_digit;
   logic       in_quotes;
   logic       in_hex;
   logic       dot_taken;
   logic       exp_taken;
   logic       refused;
   kind_type   last_kind;

   // Classes still owed by the block, oldest first
   class_type  owed_classes[$];

   function automatic void clear_scan();
      seen_count     = 2'd0;
      lead_zero      = 1'b0;
      lead_not_digit = 1'b0;
      in_quotes      = 1'b0;
      in_hex         = 1'b0;
      dot_taken      = 1'b0;
      exp_taken      = 1'b0;
      refused        = 1'b0;
      last_kind      = KIND_START;
   endfunction

   // Decode one folded character against the number grammar
   function automatic void take_char(logic [7:0] c);
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
         last_kind = KIND_DIGIT;
      end else if ((c >= CHAR_A && c <= CHAR_D) || c == CHAR_F) begin
         if (!in_hex) refused = 1'b1;
         else last_kind = KIND_DIGIT;
      end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
         if (in_hex || (last_kind != KIND_START && last_kind != KIND_EXPO)) refused = 1'b1;
         else last_kind = KIND_SIGN;
      end else if (c == CHAR_DOT) begin
         if (in_hex || dot_taken || exp_taken) begin
            refused = 1'b1;
         end else begin
            dot_taken = 1'b1;
            last_kind = KIND_DOT;
         end
      end else if (c == CHAR_E) begin
         // in hex mode e is just a digit
         if (in_hex) begin
            last_kind = KIND_EXPO;
         end else if (exp_taken) begin
            refused = 1'b1;
         end else begin
            exp_taken = 1'b1;
            last_kind = KIND_EXPO;
         end
      end else begin
         refused = 1'b1;
      end
   endfunction

   // One accepted word; returns 1 with the class when the word ends a token
   function automatic bit scan_word(logic [7:0] raw, logic last, logic empty,
                                    output class_type token_class);
      logic [7:0] c;
      logic [1:0] pos;
      if (empty) begin
         token_class = CLASS_COMMAND;
         clear_scan();
         return 1'b1;
      end
      c = raw;
      if (c >= CHAR_UP_A && c <= CHAR_UP_Z) c = c | CASE_BIT;
      pos = seen_count;
      if (pos == 2'd0) begin
         in_quotes      = (c == CHAR_QUOTE);
         lead_not_digit = !(c >= CHAR_ZERO && c <= CHAR_NINE);
         lead_zero      = (c == CHAR_ZERO);
         if (!in_quotes) take_char(c);
      end else if (!in_quotes && !refused) begin
         if (pos == 2'd1 && lead_zero && c == CHAR_X) begin
            in_hex    = 1'b1;
            last_kind = KIND_START;
         end else begin
            take_char(c);
         end
      end
      if (seen_count != 2'd2) seen_count = seen_count + 2'd1;
      if (!last) return 1'b0;

      if (in_quotes) token_class = CLASS_STRING;
      else if (pos == 2'd0 && lead_not_digit) token_class = CLASS_COMMAND;
      else if (refused) token_class = CLASS_COMMAND;
      else if (dot_taken || exp_taken) token_class = CLASS_FLOAT;
      else if (in_hex) token_class = CLASS_HEX;
      else token_class = CLASS_INT;
      clear_scan();
      return 1'b1;
   endfunction

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   // Results are checked before this edge's input word is predicted
   always @(posedge clock) begin
      class_type  word_class;
      class_type  owed;
      logic [RSP_DATA_WIDTH-1:0] want;
      if (reset) begin
         clear_scan();
         owed_classes.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (owed_classes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result word, expected none, got %h",
                        $time, rsp_tdata);
            end else begin
               owed = owed_classes.pop_front();
               want = RSP_DATA_WIDTH'(owed);
               if (rsp_tdata !== want) begin
                  error_count++;
                  $display("%0t: token class mismatch, expected %h, got %h",
                           $time, want, rsp_tdata);
               end
            end
         end
         if (req_tvalid && req_tready &&
             scan_word(req_tdata, req_tlast, req_tuser, word_class))
            owed_classes.push_back(word_class);
      end
      outstanding = owed_classes.size();
   end

endmodule

// ----- tb/numeric_token_classifier_test.sv -----
// Testbench top for the numeric token classifier: clock, reset, token stimulus and verdict
module numeric_token_classifier_test
   import ntc_pkg::*;
();

   localparam int PERIOD          = 12;
   localparam int WORDS_PER_PHASE = 600;
   localparam int DRAIN_LIMIT     = 5000;

   logic clock      = 1'b0;
   logic reset      = 1'b1;
   logic req_tvalid = 1'b0;
   logic [7:0] req_tdata = 8'h00;
   logic req_tlast  = 1'b0;
   logic req_tuser  = 1'b0;
   logic rsp_tready = 1'b0;
   logic req_tready;
   logic rsp_tvalid;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;

   int error_count;
   int outstanding;
   int unsigned send_idle_pct  = 19;
   int unsigned recv_stall_pct = 64;
   int unsigned words_sent     = 0;
   int unsigned drain_cycles;

   // Characters of the token being built
   logic [7:0] token_chars[$];

   localparam string DEC_DIGITS = "0123456789";
   localparam string HEX_DIGITS = "0123456789abcdefABCDEF";
   localparam string LETTERS    = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam string TROUBLE    = "+-.eExX0\"g ";

   always #(PERIOD / 2) clock = ~clock;

   numeric_token_classifier i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   numeric_token_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   function automatic logic [7:0] rand_char(string set);
      return set[$urandom_range(set.len() - 1)];
   endfunction

   task automatic add_chars(string set, int unsigned lo, int unsigned hi);
      int unsigned count;
      count = $urandom_range(hi, lo);
      repeat (count) token_chars.push_back(rand_char(set));
   endtask

   // Called at a falling edge; returns at the falling edge after the word is taken
   task automatic send_word(logic [7:0] c, logic last, logic empty);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tlast  <= last;
      req_tuser  <= empty;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      words_sent++;
   endtask

   // A cut token stops without its last word and is dropped by an empty word
   task automatic send_chars(bit cut);
      foreach (token_chars[i])
         send_word(token_chars[i], !cut && i == token_chars.size() - 1, 1'b0);
      if (cut) send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
   endtask

   task automatic send_text(string s, bit cut = 1'b0);
      token_chars.delete();
      for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
      send_chars(cut);
   endtask

   // Signs, digits, an optional fraction and an optional exponent
   task automatic add_float();
      if ($urandom_range(1)) token_chars.push_back(rand_char("+-"));
      add_chars(DEC_DIGITS, 0, 3);
      if ($urandom_range(2) != 0) begin
         token_chars.push_back(CHAR_DOT);
         add_chars(DEC_DIGITS, 0, 3);
      end
      if ($urandom_range(1)) begin
         token_chars.push_back(rand_char("eE"));
         if ($urandom_range(1)) token_chars.push_back(rand_char("+-"));
         add_chars(DEC_DIGITS, 0, 2);
      end
      if (token_chars.size() == 0) token_chars.push_back(rand_char(DEC_DIGITS));
   endtask

   task automatic send_random_token();
      int unsigned pick;
      int unsigned pos;
      bit cut;
      token_chars.delete();
      cut  = 1'b0;
      pick = $urandom_range(99);
      if (pick < 8) begin
         send_word(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
         return;
      end
      if (pick < 28) begin
         if ($urandom_range(3) == 0) token_chars.push_back(rand_char("+-"));
         add_chars(DEC_DIGITS, 1, 6);
      end else if (pick < 40) begin
         token_chars.push_back(CHAR_ZERO);
         token_chars.push_back(rand_char("xX"));
         add_chars(HEX_DIGITS, 0, 4);
      end else if (pick < 62) begin
         add_float();
      end else if (pick < 70) begin
         token_chars.push_back(CHAR_QUOTE);
         repeat ($urandom_range(4)) token_chars.push_back(8'($urandom_range(255, 1)));
      end else if (pick < 78) begin
         add_chars(LETTERS, 1, 5);
      end else if (pick < 88) begin
         // noise: raw bytes mixed with characters the grammar cares about
         repeat ($urandom_range(5, 1))
            token_chars.push_back($urandom_range(1) ? rand_char(TROUBLE)
                                                    : 8'($urandom_range(255, 1)));
      end else begin
         // broken number: one character spoilt, sometimes cut short
         if ($urandom_range(1)) begin
            add_float();
         end else begin
            token_chars.push_back(CHAR_ZERO);
            token_chars.push_back(rand_char("xX"));
            add_chars(HEX_DIGITS, 1, 4);
         end
         pos = $urandom_range(token_chars.size() - 1);
         token_chars[pos] = $urandom_range(1) ? rand_char(TROUBLE)
                                              : 8'($urandom_range(255, 1));
         cut = ($urandom_range(9) < 3);
      end
      send_chars(cut);
   endtask

   // Stimulus and verdict
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed tokens
      send_word(CHAR_UP_A, 1'b1, 1'b1);    // empty token, byte ignored
      send_word(CHAR_E, 1'b0, 1'b1);       // empty token without the last flag
      send_text("0X");                     // bare hex prefix
      send_text("0XeF");                   // e as a hex digit
      send_text("-1.E+5");                 // sign, dot, exponent, signed exponent
      send_word(CHAR_QUOTE, 1'b0, 1'b0);   // quoted: rest not examined
      send_word(8'hFF, 1'b1, 1'b0);
      send_text("a");                      // lone non-digit
      send_text("9");
      send_word("1", 1'b0, 1'b0);          // byte zero is not recognised
      send_word(8'h00, 1'b1, 1'b0);
      send_text("12", 1'b1);               // partial token dropped by empty word

      // Random tokens, three idling phases
      while (words_sent < WORDS_PER_PHASE) send_random_token();
      send_idle_pct  = 64;
      recv_stall_pct = 19;
      while (words_sent < 2 * WORDS_PER_PHASE) send_random_token();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      while (words_sent < 3 * WORDS_PER_PHASE) send_random_token();
      req_tvalid <= 1'b0;

      // Drain
      drain_cycles = 0;
      while (outstanding != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (10) @(negedge clock);

      if (outstanding != 0)
         $display("%0t: %0d token classes never arrived", $time, outstanding);
      if (error_count == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(PERIOD * 400000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
